// ===== rtl/mac_keyed_table_with_aging_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the MAC keyed table
// Checks compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MAC_KEYED_TABLE_WITH_AGING_TOP_MACROS_SVH
`define MAC_KEYED_TABLE_WITH_AGING_TOP_MACROS_SVH
`ifndef SYNTHESIS
// plain property, sampled on clk, off while in reset
`define MKT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// overlapping implication
`define MKT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MKT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MKT_ASSERT(lbl, clk, rstn, prop, msg)
`define MKT_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MKT_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/mkt_pkg.sv =====
// ----------------------------------------------------------------------------
// mkt_pkg
// Shared constants and types of the MAC keyed table.
// ----------------------------------------------------------------------------
package mkt_pkg;

    localparam int MKT_TABLE_SLOTS = 16;
    localparam int MKT_MAC_W       = 48;
    localparam int MKT_TIME_W      = 32;
    localparam int MKT_STATUS_W    = 2;
    localparam int MKT_SLOT_W      = 4;
    localparam int MKT_COUNT_W     = 5;

    localparam logic [MKT_TIME_W-1:0] MKT_TIMEOUT_RST = 32'd10000;

    typedef enum logic [MKT_STATUS_W-1:0] {
        ST_FOUND   = 2'd0,
        ST_CREATED = 2'd1,
        ST_FULL    = 2'd2,
        ST_SWEEP   = 2'd3
    } t_status;

    // actions carried by an input item
    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_SWEEP  = 1'b1;

endpackage

// ===== rtl/mac_keyed_table_with_aging_top.sv =====
// ----------------------------------------------------------------------------
// mac_keyed_table_with_aging_top
// Address table of TABLE_SLOTS entries with lookup/create and age-out sweep.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+--------------------------
//  in       | i_in_valid / o_in_stall                   | action, mac_address, now_ms
//  out      | o_out_valid / i_out_stall                 | status, slot, counts
//  cfg      | i_cfg_valid / o_cfg_ready, i_cfg_data     | age_timeout
//
//  An item is walked to the end before the block takes the next one: the
//  walk reads one slot per cycle from the single read port of the key/time
//  memories, the drain state takes in the last read, the final state writes
//  back and loads the result register, and the idle state takes the next item.
//  Reset (synchronous, active low) clears all active marks, the active count
//  and the timeout (10000); keys and times need no clearing.
//  A stalled result holds in the output register; the next item is accepted
//  meanwhile and waits in the final state until the register frees up.
//  The config port is always ready.
// ----------------------------------------------------------------------------
`include "mac_keyed_table_with_aging_top_macros.svh"

module mac_keyed_table_with_aging_top
    import mkt_pkg::*;
#(
    parameter int TABLE_SLOTS = MKT_TABLE_SLOTS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input items
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_action,
    input  logic [MKT_MAC_W-1:0]    i_mac_address,
    input  logic [MKT_TIME_W-1:0]   i_now_ms,
    // result items
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [MKT_STATUS_W-1:0] o_status,
    output logic [MKT_SLOT_W-1:0]   o_slot_index,
    output logic [MKT_COUNT_W-1:0]  o_active_count,
    output logic [MKT_COUNT_W-1:0]  o_removed_count,
    // configuration
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [MKT_TIME_W-1:0]   i_cfg_data
);

    localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_DRAIN = 4'b0100,
        S_FIN   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // item held during the walk
    logic                  r_act;
    logic [MKT_MAC_W-1:0]  r_mac;
    logic [MKT_TIME_W-1:0] r_now;

    // walk pointers: r_idx issues reads, r_cidx tags the returning data
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_cidx;
    logic          r_cvld;

    // search results
    logic          r_hit_vld, r_spr_vld;
    logic [IW-1:0] r_hit_idx, r_spr_idx;
    logic [CW-1:0] r_rm_cnt;

    // table state
    logic [TABLE_SLOTS-1:0] r_active;
    logic [CW-1:0]          r_active_cnt;
    logic [MKT_TIME_W-1:0]  r_timeout;

    // result register
    logic                    r_out_valid;
    t_status                 r_out_status;
    logic [IW-1:0]           r_out_slot;
    logic [CW-1:0]           r_out_active;
    logic [CW-1:0]           r_out_removed;

    logic [MKT_MAC_W-1:0]  w_key;
    logic [MKT_TIME_W-1:0] w_ts;
    logic                  w_slot_act;
    logic                  w_hit, w_expire;
    logic                  w_accept;
    logic                  w_load;
    logic                  w_create;
    logic                  w_found;
    logic [IW-1:0]         w_wr_addr;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    // final cycle completes once the result register can take the item
    assign w_load      = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);

    assign w_found   = (r_act == ACT_LOOKUP) && r_hit_vld;
    assign w_create  = (r_act == ACT_LOOKUP) && !r_hit_vld && r_spr_vld;
    assign w_wr_addr = r_hit_vld ? r_hit_idx : r_spr_idx;
    assign w_slot_act = r_cvld && r_active[r_cidx];

    mkt_store #(
        .SLOTS (TABLE_SLOTS),
        .IW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_addr (r_idx),
        .i_wr_addr (w_wr_addr),
        .i_key_we  (w_load && w_create),
        .i_key_wd  (r_mac),
        .i_ts_we   (w_load && (w_create || w_found)),
        .i_ts_wd   (r_now),
        .o_key     (w_key),
        .o_ts      (w_ts)
    );

    mkt_cmp u_cmp (
        .i_sweep   (r_act == ACT_SWEEP),
        .i_active  (w_slot_act),
        .i_key     (w_key),
        .i_addr    (r_mac),
        .i_last    (w_ts),
        .i_now     (r_now),
        .i_timeout (r_timeout),
        .o_hit     (w_hit),
        .o_expire  (w_expire)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) n_state = S_RD;
            end
            S_RD: begin
                if (r_idx == LAST_IDX) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_FIN;
            end
            S_FIN: begin
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cvld       <= 1'b0;
            r_active     <= '0;
            r_active_cnt <= '0;
            r_timeout    <= MKT_TIMEOUT_RST;
            r_out_valid  <= 1'b0;
            r_idx        <= '0;
            r_hit_vld    <= 1'b0;
            r_spr_vld    <= 1'b0;
            r_rm_cnt     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end

            // data for r_cidx returns the cycle after its read
            r_cvld <= (r_state == S_RD);
            r_cidx <= r_idx;

            if (w_accept) begin
                r_idx     <= '0;
                r_hit_vld <= 1'b0;
                r_spr_vld <= 1'b0;
                r_rm_cnt  <= '0;
            end else if (r_state == S_RD && r_idx != LAST_IDX) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_cvld) begin
                if (w_hit && !r_hit_vld) begin
                    r_hit_vld <= 1'b1;
                    r_hit_idx <= r_cidx;
                end
                if (!r_active[r_cidx] && !r_spr_vld) begin
                    r_spr_vld <= 1'b1;
                    r_spr_idx <= r_cidx;
                end
                if (w_expire) begin
                    r_active[r_cidx] <= 1'b0;
                    r_active_cnt     <= r_active_cnt - 1'b1;
                    r_rm_cnt         <= r_rm_cnt + 1'b1;
                end
            end

            if (w_load && w_create) begin
                r_active[r_spr_idx] <= 1'b1;
                r_active_cnt        <= r_active_cnt + 1'b1;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_action;
            r_mac <= i_mac_address;
            r_now <= i_now_ms;
        end
        if (w_load) begin
            if (r_act == ACT_SWEEP) begin
                r_out_status  <= ST_SWEEP;
                r_out_slot    <= '0;
                r_out_active  <= r_active_cnt;
                r_out_removed <= r_rm_cnt;
            end else if (r_hit_vld) begin
                r_out_status  <= ST_FOUND;
                r_out_slot    <= r_hit_idx;
                r_out_active  <= r_active_cnt;
                r_out_removed <= '0;
            end else if (r_spr_vld) begin
                r_out_status  <= ST_CREATED;
                r_out_slot    <= r_spr_idx;
                r_out_active  <= r_active_cnt + 1'b1;
                r_out_removed <= '0;
            end else begin
                r_out_status  <= ST_FULL;
                r_out_slot    <= '0;
                r_out_active  <= r_active_cnt;
                r_out_removed <= '0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_slot_index    = MKT_SLOT_W'(r_out_slot);
    assign o_active_count  = MKT_COUNT_W'(r_out_active);
    assign o_removed_count = MKT_COUNT_W'(r_out_removed);

    // checks
    `MKT_ASSERT(a_cnt_match, i_clk, i_rst_n, int'(r_active_cnt) == $countones(r_active), "active count out of step with marks")
    `MKT_ASSERT_NXT(a_accept_walk, i_clk, i_rst_n, w_accept, r_state == S_RD, "accepted item did not start a walk")
    `MKT_ASSERT_NXT(a_fin_hold, i_clk, i_rst_n, r_state == S_FIN && r_out_valid && i_out_stall, r_state == S_FIN, "result dropped while output stalled")
    `MKT_ASSERT_IMP(a_no_overfill, i_clk, i_rst_n, w_load && w_create, r_active_cnt < FULL_CNT, "slot created in a full table")

endmodule

// ===== rtl/mkt_store.sv =====
// ----------------------------------------------------------------------------
// mkt_store
// Key and last-seen memories, one write and one registered read port.
// ----------------------------------------------------------------------------
module mkt_store
    import mkt_pkg::*;
#(
    parameter int SLOTS = MKT_TABLE_SLOTS,
    parameter int IW    = 4
) (
    input  logic                  i_clk,
    input  logic [IW-1:0]         i_rd_addr,
    input  logic [IW-1:0]         i_wr_addr,
    input  logic                  i_key_we,
    input  logic [MKT_MAC_W-1:0]  i_key_wd,
    input  logic                  i_ts_we,
    input  logic [MKT_TIME_W-1:0] i_ts_wd,
    output logic [MKT_MAC_W-1:0]  o_key,
    output logic [MKT_TIME_W-1:0] o_ts
);

    logic [MKT_MAC_W-1:0]  r_key_mem [SLOTS];
    logic [MKT_TIME_W-1:0] r_ts_mem  [SLOTS];
    logic [MKT_MAC_W-1:0]  r_key;
    logic [MKT_TIME_W-1:0] r_ts;

    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_wr_addr] <= i_key_wd;
        end
        if (i_ts_we) begin
            r_ts_mem[i_wr_addr] <= i_ts_wd;
        end
        r_key <= r_key_mem[i_rd_addr];
        r_ts  <= r_ts_mem[i_rd_addr];
    end

    assign o_key = r_key;
    assign o_ts  = r_ts;

endmodule

// ===== rtl/mkt_cmp.sv =====
// ----------------------------------------------------------------------------
// mkt_cmp
// Per-slot compare unit: key match for lookups, age check for sweeps.
// ----------------------------------------------------------------------------
module mkt_cmp
    import mkt_pkg::*;
(
    input  logic                  i_sweep,
    input  logic                  i_active,
    input  logic [MKT_MAC_W-1:0]  i_key,
    input  logic [MKT_MAC_W-1:0]  i_addr,
    input  logic [MKT_TIME_W-1:0] i_last,
    input  logic [MKT_TIME_W-1:0] i_now,
    input  logic [MKT_TIME_W-1:0] i_timeout,
    output logic                  o_hit,
    output logic                  o_expire
);

    logic [MKT_TIME_W-1:0] w_age;

    // wrapping age, modulo 2^32
    assign w_age    = i_now - i_last;
    assign o_hit    = !i_sweep && i_active && (i_key == i_addr);
    assign o_expire = i_sweep && i_active && (w_age > i_timeout);

endmodule

// ===== tb/mkt_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkt_table_checker
// Watches the item, result and timeout channels of the MAC keyed table, keeps
// its own copy of the table and the timeout, and compares every result with
// the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mkt_table_checker
    import mkt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic                    i_action,
    input  logic [MKT_MAC_W-1:0]    i_mac_address,
    input  logic [MKT_TIME_W-1:0]   i_now_ms,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic [MKT_STATUS_W-1:0] i_status,
    input  logic [MKT_SLOT_W-1:0]   i_slot_index,
    input  logic [MKT_COUNT_W-1:0]  i_active_count,
    input  logic [MKT_COUNT_W-1:0]  i_removed_count,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [MKT_TIME_W-1:0]   i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        t_status                 status;
        logic [MKT_SLOT_W-1:0]   slot_index;
        logic [MKT_COUNT_W-1:0]  active_count;
        logic [MKT_COUNT_W-1:0]  removed_count;
    } t_table_result;

    logic [MKT_MAC_W-1:0]  slot_key  [MKT_TABLE_SLOTS];
    logic                  slot_live [MKT_TABLE_SLOTS];
    logic [MKT_TIME_W-1:0] slot_seen [MKT_TABLE_SLOTS];
    logic [MKT_TIME_W-1:0] shadow_timeout;
    t_table_result         expected_results [$];
    int                    fail_total  = 0;
    int                    outstanding = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = outstanding;

    // applies one item to the shadow table and returns the result it gives
    function automatic t_table_result apply_item(input logic                  act,
                                                 input logic [MKT_MAC_W-1:0]  mac,
                                                 input logic [MKT_TIME_W-1:0] now);
        t_table_result         res;
        int                    hit;
        int                    spare;
        int                    live;
        logic [MKT_TIME_W-1:0] age;
        res   = '0;
        hit   = -1;
        spare = -1;
        live  = 0;
        if (act == ACT_SWEEP) begin
            res.status = ST_SWEEP;
            for (int i = 0; i < MKT_TABLE_SLOTS; i++) begin
                if (slot_live[i]) begin
                    age = now - slot_seen[i];
                    if (age > shadow_timeout) begin
                        slot_live[i] = 1'b0;
                        res.removed_count++;
                    end
                end
            end
        end else begin
            for (int i = 0; i < MKT_TABLE_SLOTS; i++) begin
                if (slot_live[i]) begin
                    if (hit < 0 && slot_key[i] == mac) hit = i;
                end else if (spare < 0) begin
                    spare = i;
                end
            end
            if (hit >= 0) begin
                res.status     = ST_FOUND;
                res.slot_index = MKT_SLOT_W'(hit);
                slot_seen[hit] = now;
            end else if (spare >= 0) begin
                res.status       = ST_CREATED;
                res.slot_index   = MKT_SLOT_W'(spare);
                slot_key[spare]  = mac;
                slot_live[spare] = 1'b1;
                slot_seen[spare] = now;
            end else begin
                res.status = ST_FULL;
            end
        end
        for (int i = 0; i < MKT_TABLE_SLOTS; i++) begin
            if (slot_live[i]) live++;
        end
        res.active_count = MKT_COUNT_W'(live);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < MKT_TABLE_SLOTS; i++) slot_live[i] = 1'b0;
            shadow_timeout = MKT_TIMEOUT_RST;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) shadow_timeout = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                expected_results.push_back(apply_item(i_action, i_mac_address, i_now_ms));
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: status %0d slot %0d",
                           i_status, i_slot_index);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_total++;
                    end
                    if (i_slot_index !== want.slot_index) begin
                        $error("slot_index: expected %0d, actual %0d",
                               want.slot_index, i_slot_index);
                        fail_total++;
                    end
                    if (i_active_count !== want.active_count) begin
                        $error("active_count: expected %0d, actual %0d",
                               want.active_count, i_active_count);
                        fail_total++;
                    end
                    if (i_removed_count !== want.removed_count) begin
                        $error("removed_count: expected %0d, actual %0d",
                               want.removed_count, i_removed_count);
                        fail_total++;
                    end
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the MAC keyed table with a directed opening (fill to full, found and
// created slots, sweeps on the timeout boundary, time wrap, empty sweep) and
// then random phases under several aging timeouts, with bursty input, random
// result stalls and one long hold-off. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb;
    import mkt_pkg::*;

    // long result hold-off, in cycles; long enough to back the block up
    localparam int HOLD_CYCLES = 300;
    // address pool for random lookups: more addresses than slots, so the
    // table fills, hits and overflows
    localparam int POOL_SIZE   = 24;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic                    i_action;
    logic [MKT_MAC_W-1:0]    i_mac_address;
    logic [MKT_TIME_W-1:0]   i_now_ms;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic [MKT_STATUS_W-1:0] o_status;
    logic [MKT_SLOT_W-1:0]   o_slot_index;
    logic [MKT_COUNT_W-1:0]  o_active_count;
    logic [MKT_COUNT_W-1:0]  o_removed_count;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [MKT_TIME_W-1:0]   i_cfg_data;

    int   fail_count;
    int   pending;
    logic hold_off_req = 1'b0;
    int   burst_left   = 0;

    mac_keyed_table_with_aging_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_mac_address   (i_mac_address),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_slot_index    (o_slot_index),
        .o_active_count  (o_active_count),
        .o_removed_count (o_removed_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    mkt_table_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_mac_address   (i_mac_address),
        .i_now_ms        (i_now_ms),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_slot_index    (o_slot_index),
        .i_active_count  (o_active_count),
        .i_removed_count (o_removed_count),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // hard stop: about 1000 items plus gaps and stalls end well before it
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side. Stall pattern changes at random between open, light,
    // heavy and periodic. Once the stimulus asks for it, the sink holds off
    // once, with the stall held high, so the block fills up and pushes back
    // on the item side.
    initial begin : result_sink
        typedef enum {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} t_sink_mode;
        t_sink_mode mode;
        int         left;
        int         tick;
        bit         hold_done;
        mode        = SINK_OPEN;
        left        = 0;
        tick        = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_done) begin
                hold_done   = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                if (left == 0) begin
                    mode = t_sink_mode'($urandom_range(0, 3));
                    left = $urandom_range(10, 120);
                end
                left--;
                tick++;
                case (mode)
                    SINK_OPEN:  i_out_stall <= 1'b0;
                    SINK_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                    SINK_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default:    i_out_stall <= ((tick % 8) < 5);
                endcase
            end
        end
    end

    // Offers one item and returns at the edge that takes it. Items go out in
    // bursts; between bursts valid drops for a random gap, from none up to
    // longer than a full block pass, so gaps land on every step of the walk.
    task automatic offer_item(input logic                  act,
                              input logic [MKT_MAC_W-1:0]  mac,
                              input logic [MKT_TIME_W-1:0] now);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: gap = 0;
                5, 6, 7:       gap = $urandom_range(1, 5);
                8:             gap = $urandom_range(6, 20);
                default:       gap = $urandom_range(20, 40);
            endcase
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_mac_address <= mac;
        i_now_ms      <= now;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
    endtask

    // Drops valid and waits until every result is back, then lets the walk
    // of any straggler finish.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * MKT_TABLE_SLOTS) @(negedge i_clk);
    endtask

    // timeout writes only happen with the block drained
    task automatic write_timeout(input logic [MKT_TIME_W-1:0] value);
        settle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Random phase: mostly lookups from a small address pool so slots get
    // found, created and the table fills; some sweeps, some lookups of fresh
    // random addresses. Time creeps forward by up to step_max per item and
    // now and then jumps anywhere, which also exercises the wrap.
    task automatic run_random_phase(input int n_items, input int step_max,
                                    input bit with_hold);
        logic [MKT_MAC_W-1:0]  pool [POOL_SIZE];
        logic [MKT_TIME_W-1:0] now;
        logic [MKT_MAC_W-1:0]  mac;
        logic                  act;
        int                    pick;
        for (int k = 0; k < POOL_SIZE; k++) pool[k] = {16'($urandom), 32'($urandom)};
        now = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if (with_hold && n == n_items / 4) hold_off_req = 1'b1;
            if ($urandom_range(0, 39) == 0)
                now = $urandom;
            else
                now = now + $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            act  = ACT_LOOKUP;
            mac  = pool[$urandom_range(0, POOL_SIZE - 1)];
            if (pick < 14) begin
                // the address is don't-care on a sweep; keep it noisy
                act = ACT_SWEEP;
                mac = {16'($urandom), 32'($urandom)};
            end else if (pick >= 92) begin
                mac = {16'($urandom), 32'($urandom)};
            end
            offer_item(act, mac, now);
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_action      = ACT_LOOKUP;
        i_mac_address = '0;
        i_now_ms      = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed, default timeout of 10000 ---
        // lowest and highest address and time, then a hit on slot 0
        offer_item(ACT_LOOKUP, '0, '0);
        offer_item(ACT_LOOKUP, '1, '1);
        offer_item(ACT_LOOKUP, '0, 32'd100);
        // fill the remaining 14 slots
        for (int k = 0; k < 14; k++)
            offer_item(ACT_LOOKUP, 48'h0000_0000_0100 + MKT_MAC_W'(k), 32'd1000);
        // one more new address: table full
        offer_item(ACT_LOOKUP, 48'h8000_0000_0000, 32'd1000);
        // slot 0 is exactly at the timeout (kept); slot 1 was stamped just
        // before the wrap, so its age is 10101 (freed)
        offer_item(ACT_SWEEP, '0, 32'd10100);
        // new address takes the lowest free slot, slot 1
        offer_item(ACT_LOOKUP, 48'h5555_AAAA_5555, 32'd10100);
        // past the timeout for slot 0, one past it for the bulk fill; slot 1 stays
        offer_item(ACT_SWEEP, 48'hAAAA_5555_AAAA, 32'd11001);
        // clears the last entry, then a sweep of an empty table
        offer_item(ACT_SWEEP, '1, 32'hFFFF_FFFF);
        offer_item(ACT_SWEEP, '0, '0);

        // --- random phases, timeout extremes included ---
        write_timeout(32'd0);
        run_random_phase(200, 3, 1'b0);
        write_timeout(32'hFFFF_FFFF);
        run_random_phase(200, 100000, 1'b0);
        write_timeout(32'd700);
        run_random_phase(200, 60, 1'b1);
        write_timeout($urandom_range(200, 5000));
        run_random_phase(200, 300, 1'b0);
        write_timeout($urandom);
        run_random_phase(200, 1 << 28, 1'b0);

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
